// ----- sv/spadd_pkg.sv -----
// spadd_pkg: request and response types, function and status codes
// for the sparse polynomial add unit. No dependencies.
`default_nettype none

package spadd_pkg;

	localparam logic [1:0] FUNC_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_SECOND = 2'd1;
	localparam logic [1:0] FUNC_ADD         = 2'd2;

	localparam logic [1:0] STATUS_TERM  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] term_coef;
		logic [15:0]        term_power;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_coef;
		logic [15:0]        out_power;
		logic               is_last;
		logic [1:0]         status;
	} rsp_t;

endpackage

`default_nettype wire

// ----- sv/sparse_polynomial_add_unit.sv -----
// sparse_polynomial_add_unit: two term buffers merged by descending power
// through one shared adder and power compare. Depends on spadd_pkg.
//
//   channel | signals                       | moves
//   req     | req_valid, req_ready, req     | load or add request (req_t)
//   rsp     | rsp_valid, rsp_ready, rsp     | result term (rsp_t)
//
// a load into a full buffer gives one result. an add emits each term through
// a fetch step, which reads the buffer heads from the term memories, and an
// emit step, which compares powers, adds and registers the term. an add on
// two empty buffers gives one result. reset clears both counts; buffers need
// no clearing. rsp stalls hold the merge in its emit step. req_ready is low
// while an add runs.
`default_nettype none

module sparse_polynomial_add_unit
	import spadd_pkg::*;
#(
	parameter int MAX_TERMS = 32
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  wire  rsp_ready,
	output rsp_t rsp
);

	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TERMS);

	typedef struct packed {
		logic signed [31:0] coef;
		logic [15:0]        power;
	} term_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	term_t a_mem [MAX_TERMS];
	term_t b_mem [MAX_TERMS];
	term_t a_rd_q, b_rd_q;

	state_t        state_q;
	logic [CW-1:0] a_cnt_q, b_cnt_q;
	logic [CW-1:0] i_q, j_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          req_acc, slot_free;
	logic          a_wr, b_wr;
	logic          load_drop, add_empty, rsp_set;
	logic          a_has, b_has, take_a, take_b;
	logic [CW-1:0] i_nx, j_nx;
	logic signed [31:0] sum_coef;
	logic [15:0]   sel_power;
	logic          run_done;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && slot_free;
	assign req_acc   = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign a_wr = req_acc && (req.func == FUNC_LOAD_FIRST) && (a_cnt_q < FULL_CNT);
	assign b_wr = req_acc && (req.func == FUNC_LOAD_SECOND) && (b_cnt_q < FULL_CNT);

	assign load_drop = req_acc && ((req.func == FUNC_LOAD_FIRST) ||
		(req.func == FUNC_LOAD_SECOND)) && !a_wr && !b_wr;
	assign add_empty = req_acc && (req.func == FUNC_ADD) &&
		(a_cnt_q == '0) && (b_cnt_q == '0);
	assign rsp_set   = load_drop || add_empty || ((state_q == ST_EMIT) && slot_free);

	// shared compare and adder
	always_comb begin
		a_has     = i_q < a_cnt_q;
		b_has     = j_q < b_cnt_q;
		take_a    = a_has && (!b_has || (a_rd_q.power >= b_rd_q.power));
		take_b    = b_has && (!a_has || (b_rd_q.power >= a_rd_q.power));
		sum_coef  = (take_a ? a_rd_q.coef : 32'sd0) + (take_b ? b_rd_q.coef : 32'sd0);
		sel_power = take_a ? a_rd_q.power : b_rd_q.power;
		i_nx      = i_q + CW'(take_a);
		j_nx      = j_q + CW'(take_b);
		run_done  = (i_nx >= a_cnt_q) && (j_nx >= b_cnt_q);
	end

	// term memories
	always_ff @(posedge clk) begin
		if (a_wr) begin
			a_mem[a_cnt_q[IW-1:0]] <= '{coef: req.term_coef, power: req.term_power};
		end
		if (b_wr) begin
			b_mem[b_cnt_q[IW-1:0]] <= '{coef: req.term_coef, power: req.term_power};
		end
		if (state_q == ST_FETCH) begin
			if (i_q < a_cnt_q) begin
				a_rd_q <= a_mem[i_q[IW-1:0]];
			end
			if (j_q < b_cnt_q) begin
				b_rd_q <= b_mem[j_q[IW-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_cnt_q     <= '0;
			b_cnt_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (a_wr) begin
						a_cnt_q <= a_cnt_q + 1'b1;
					end
					if (b_wr) begin
						b_cnt_q <= b_cnt_q + 1'b1;
					end
					if (req_acc) begin
						case (req.func)
							FUNC_LOAD_FIRST, FUNC_LOAD_SECOND: begin
								if (!a_wr && !b_wr) begin
									rsp_q <= '{out_coef: 32'sd0, out_power: 16'd0,
										is_last: 1'b1, status: STATUS_FULL};
								end
							end
							FUNC_ADD: begin
								if ((a_cnt_q == '0) && (b_cnt_q == '0)) begin
									rsp_q <= '{out_coef: 32'sd0, out_power: 16'd0,
										is_last: 1'b1, status: STATUS_EMPTY};
								end else begin
									i_q     <= '0;
									j_q     <= '0;
									state_q <= ST_FETCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						rsp_q <= '{out_coef: sum_coef, out_power: sel_power,
							is_last: run_done, status: STATUS_TERM};
						i_q     <= i_nx;
						j_q     <= j_nx;
						state_q <= run_done ? ST_IDLE : ST_FETCH;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
